### rtl/assert_macros.svh
// Assertion helpers shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SDF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define SDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sdf_pkg.sv
package sdf_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'hAA;
   localparam logic [8:0] MODULUS    = 9'd255;

   localparam int TIMEOUT_REG_W = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEN       = 2'd1;

   localparam logic [7:0] MAX_LEN_RESET = 8'd255;

   localparam logic [1:0] VERDICT_PENDING  = 2'd0;
   localparam logic [1:0] VERDICT_GOOD     = 2'd1;
   localparam logic [1:0] VERDICT_BAD_SUM  = 2'd2;
   localparam logic [1:0] VERDICT_TOO_LONG = 2'd3;

   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_CK_HI,
      PH_CK_LO,
      PH_LEN,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] payload_byte;
      logic [7:0] byte_index;
      logic       last;
      logic [1:0] verdict;
      logic [7:0] packet_len;
   } result_type;

   typedef struct packed {
      logic       push;
      result_type entry;
   } queue_push_type;

endpackage

### rtl/sdf_front.sv
`include "assert_macros.svh"

module sdf_front import sdf_pkg::*; #(
   parameter int TIMEOUT_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_action,
   input  logic [7:0]               req_rx_byte,
   input  logic                     csr_valid,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   input  logic                     queue_full,
   output queue_push_type           queue_push
);

   localparam int CMP_W = (TIMEOUT_WIDTH > TIMEOUT_REG_W) ? TIMEOUT_WIDTH : TIMEOUT_REG_W;

   phase_type                phase_ff, phase_in;
   logic [15:0]              ck_ff, ck_in;
   logic [7:0]               len_ff, len_in;
   logic [7:0]               count_ff, count_in;
   logic [7:0]               low_ff, low_in;
   logic [7:0]               high_ff, high_in;
   logic [TIMEOUT_WIDTH-1:0] idle_ff, idle_in;
   logic [TIMEOUT_REG_W-1:0] timeout_ff;
   logic [7:0]               max_len_ff;

   logic                     accept;
   logic [TIMEOUT_WIDTH-1:0] idle_inc;
   logic                     timed_out;
   logic [7:0]               low_new, high_new, len_seed, count_next;
   logic                     fin, fits, sum_match;
   logic [1:0]               final_verdict;

   function automatic logic [7:0] mod_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= MODULUS)
         s = s - MODULUS;
      return s[7:0];
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   assign idle_inc   = (idle_ff == '1) ? idle_ff : idle_ff + 1'b1;
   assign timed_out  = (phase_ff != PH_HUNT) && (timeout_ff != '0) &&
                       (CMP_W'(idle_inc) >= CMP_W'(timeout_ff));
   assign low_new    = mod_add(low_ff, req_rx_byte);
   assign high_new   = mod_add(high_ff, low_new);
   assign len_seed   = (req_rx_byte == MODULUS[7:0]) ? 8'd0 : req_rx_byte;
   assign count_next = count_ff + 8'd1;
   assign fin        = count_next >= len_ff;
   assign fits       = len_ff <= max_len_ff;
   assign sum_match  = {high_new, low_new} == ck_ff;
   assign final_verdict = !fits ? VERDICT_TOO_LONG :
                          (sum_match ? VERDICT_GOOD : VERDICT_BAD_SUM);

   // next state
   always_comb begin
      phase_in = phase_ff;
      ck_in    = ck_ff;
      len_in   = len_ff;
      count_in = count_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      idle_in  = idle_ff;
      if (accept) begin
         if (req_action == ACTION_TICK) begin
            idle_in = idle_inc;
            if (timed_out)
               phase_in = PH_HUNT;
         end else begin
            idle_in = '0;
            unique case (phase_ff)
               PH_CK_HI: begin
                  ck_in    = {req_rx_byte, 8'd0};
                  phase_in = PH_CK_LO;
               end
               PH_CK_LO: begin
                  ck_in    = {ck_ff[15:8], req_rx_byte};
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  len_in   = req_rx_byte;
                  count_in = '0;
                  low_in   = len_seed;
                  high_in  = len_seed;
                  phase_in = (req_rx_byte == 8'd0) ? PH_HUNT : PH_DATA;
               end
               PH_DATA: begin
                  low_in   = low_new;
                  high_in  = high_new;
                  count_in = count_next;
                  if (fin)
                     phase_in = PH_HUNT;
               end
               default: begin
                  phase_in = (req_rx_byte == SYNC_BYTE) ? PH_CK_HI : PH_HUNT;
               end
            endcase
         end
      end
   end

   // result generation
   always_comb begin
      queue_push.push  = 1'b0;
      queue_push.entry = '{data_valid: 1'b0, payload_byte: 8'd0, byte_index: 8'd0,
                           last: 1'b0, verdict: VERDICT_PENDING, packet_len: len_ff};
      if (accept && req_action == ACTION_BYTE) begin
         unique case (phase_ff)
            PH_LEN: begin
               if (req_rx_byte == 8'd0) begin
                  queue_push.push             = 1'b1;
                  queue_push.entry.last       = 1'b1;
                  queue_push.entry.packet_len = 8'd0;
                  queue_push.entry.verdict    = (ck_ff == 16'd0) ? VERDICT_GOOD
                                                                 : VERDICT_BAD_SUM;
               end
            end
            PH_DATA: begin
               if (fits) begin
                  queue_push.push               = 1'b1;
                  queue_push.entry.data_valid   = 1'b1;
                  queue_push.entry.payload_byte = req_rx_byte;
                  queue_push.entry.byte_index   = count_ff;
                  queue_push.entry.last         = fin;
                  queue_push.entry.verdict      = fin ? final_verdict : VERDICT_PENDING;
               end else if (fin) begin
                  queue_push.push             = 1'b1;
                  queue_push.entry.last       = 1'b1;
                  queue_push.entry.verdict    = VERDICT_TOO_LONG;
               end
            end
            default: begin
               queue_push.push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         ck_ff      <= '0;
         len_ff     <= '0;
         count_ff   <= '0;
         low_ff     <= '0;
         high_ff    <= '0;
         idle_ff    <= '0;
         timeout_ff <= '0;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         phase_ff <= phase_in;
         ck_ff    <= ck_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         idle_ff  <= idle_in;
         if (csr_valid) begin
            if (csr_index == CSR_TIMEOUT_TICKS)
               timeout_ff <= csr_wdata[TIMEOUT_REG_W-1:0];
            else if (csr_index == CSR_MAX_LEN)
               max_len_ff <= csr_wdata[7:0];
         end
      end
   end

   `SDF_ASSERT(a_pending_not_last, clock, reset,
      !queue_push.push || queue_push.entry.last || queue_push.entry.verdict == VERDICT_PENDING,
      "result without last carries a verdict")
   `SDF_ASSERT_NEXT(a_last_returns_hunt, clock, reset,
      queue_push.push && queue_push.entry.last, phase_ff == PH_HUNT,
      "deframer not hunting after packet end")
   `SDF_ASSERT_NEXT(a_byte_clears_idle, clock, reset,
      accept && req_action == ACTION_BYTE, idle_ff == '0,
      "idle counter not cleared by received byte")

endmodule

### rtl/sdf_queue.sv
`include "assert_macros.svh"

module sdf_queue import sdf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_push_type queue_push,
   output logic           queue_full,
   output logic           out_valid,
   input  logic           out_ready,
   output result_type     out_entry
);

   result_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   pop;

   assign queue_full = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign out_valid  = count_ff != '0;
   assign out_entry  = mem_ff[rd_ptr_ff];
   assign pop        = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (queue_push.push)
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (queue_push.push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !queue_push.push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (queue_push.push)
         mem_ff[wr_ptr_ff] <= queue_push.entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SDF_ASSERT(a_no_overflow, clock, reset, !(queue_full && queue_push.push),
      "push into full queue")
   `SDF_ASSERT(a_count_bound, clock, reset, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH),
      "queue count out of range")
   `SDF_ASSERT_NEXT(a_pop_drains, clock, reset, pop && !queue_push.push,
      count_ff == $past(count_ff) - 1'b1, "queue count not reduced by pop")

endmodule

### rtl/serial_packet_deframer.sv
// Serial packet deframer with Fletcher-16 check.
// Request channel (req_valid/req_ready): req_action 0 carries a received
// byte in req_rx_byte, 1 signals one timer tick. Frames are 0xAA, checksum
// high, checksum low, length, then that many payload bytes.
// Response channel (rsp_valid/rsp_ready): one transaction per payload byte
// of a packet within max_len, the last of them (last = 1) with the verdict;
// a packet over max_len gives only its ending transaction with verdict 3;
// zero-length packets end on the length byte.
// CSR channel (csr_valid/csr_ready, always ready): index 0 timeout_ticks,
// index 1 max_len; write only while the block is idle.
// Throughput: one request per cycle while req_ready is high. A response
// is registered in the result queue and shown on rsp_* once the entries
// ahead of it have been taken.
// Reset: hunting for a start byte, queue empty, timeout_ticks 0 (off),
// max_len 255.
// Stall: a two-entry result queue decouples the sides; whenever the queue is
// full, req_ready drops and requests wait.
module serial_packet_deframer import sdf_pkg::*; #(
   parameter int TIMEOUT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_data_valid,
   output logic [7:0]             rsp_payload_byte,
   output logic [7:0]             rsp_byte_index,
   output logic                   rsp_last,
   output logic [1:0]             rsp_verdict,
   output logic [7:0]             rsp_packet_len,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   queue_push_type queue_push;
   logic           queue_full;
   result_type     out_entry;

   assign csr_ready = 1'b1;

   sdf_front #(
      .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .queue_full  (queue_full),
      .queue_push  (queue_push)
   );

   sdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_push (queue_push),
      .queue_full (queue_full),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_entry  (out_entry)
   );

   assign rsp_data_valid   = out_entry.data_valid;
   assign rsp_payload_byte = out_entry.payload_byte;
   assign rsp_byte_index   = out_entry.byte_index;
   assign rsp_last         = out_entry.last;
   assign rsp_verdict      = out_entry.verdict;
   assign rsp_packet_len   = out_entry.packet_len;

endmodule
